@@ design/mflg_pkg.sv @@
`timescale 1ns / 1ps
package mflg_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int MAX_EDGES_DEF    = 32;

  localparam int FLOW_W  = 38;
  localparam int CAP_W   = 32;
  localparam int EFLOW_W = 34;
  localparam int RES_W   = 35;
  localparam int WANT_W  = 41;
  localparam int VC_W    = 5;
  localparam int EP_W    = 4;
  localparam int CMP_W   = 8;

  localparam logic [WANT_W-1:0] PUSH_LIMIT = 41'h100_0000_0000;
  localparam logic [VC_W-1:0]   VC_RESET   = 5'd2;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_SOLVE = 1'b1
  } op_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_START,
    DP_BFS_INIT,
    DP_BFS_POP,
    DP_ARC_RD,
    DP_BFS_EVAL,
    DP_DFS_INIT,
    DP_ROOT,
    DP_NA_RD,
    DP_DESCEND,
    DP_SKIP,
    DP_RET_WANT,
    DP_RET_GOT,
    DP_POP,
    DP_ADD_TOTAL,
    DP_UPD,
    DP_EMIT_TOT,
    DP_EMIT_RD,
    DP_EMIT_EDGE,
    DP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic in_solve;
    logic bfs_empty;
    logic sink_reached;
    logic bfs_arc_end;
    logic na_end;
    logic eligible;
    logic at_term;
    logic depth_zero;
    logic ret_zero;
    logic want_eq_ret;
    logic out_free;
    logic emit_end;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BFS_INIT,
    S_BFS_POP,
    S_BFS_RD,
    S_BFS_EVAL,
    S_DFS_INIT,
    S_ROOT,
    S_ENTER,
    S_SCAN,
    S_EVAL,
    S_RET,
    S_UPD_RD,
    S_UPD,
    S_EMIT_TOT,
    S_EMIT_RD,
    S_EMIT_EDGE
  } ctrl_state_t;

endpackage

@@ design/mflg_if.sv @@
`timescale 1ns / 1ps
interface mflg_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [mflg_pkg::EP_W-1:0]           from_vertex;
  logic [mflg_pkg::EP_W-1:0]           to_vertex;
  logic [mflg_pkg::CAP_W-1:0]          capacity;

  modport source(output valid, operation, from_vertex, to_vertex, capacity, input ready);
  modport sink(input valid, operation, from_vertex, to_vertex, capacity, output ready);
endinterface

interface mflg_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mflg_pkg::FLOW_W-1:0]  flow_value;
  logic                                is_total;
  logic                                last_result;

  modport source(output valid, flow_value, is_total, last_result, input ready);
  modport sink(input valid, flow_value, is_total, last_result, output ready);
endinterface

@@ design/mflg_ctrl.sv @@
`timescale 1ns / 1ps
module mflg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mflg_pkg::dp_stat_t stat,
  output mflg_pkg::dp_cmd_t  cmd
);

  mflg_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mflg_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = mflg_pkg::DP_NOP;
    in_ready  = 1'b0;
    case (state_r)
      mflg_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (stat.in_solve) begin
            cmd.op    = mflg_pkg::DP_START;
            state_nxt = mflg_pkg::S_BFS_INIT;
          end else begin
            cmd.op = mflg_pkg::DP_LOAD;
          end
        end
      end
      mflg_pkg::S_BFS_INIT: begin
        cmd.op    = mflg_pkg::DP_BFS_INIT;
        state_nxt = mflg_pkg::S_BFS_POP;
      end
      mflg_pkg::S_BFS_POP: begin
        if (stat.bfs_empty) begin
          state_nxt = stat.sink_reached ? mflg_pkg::S_DFS_INIT : mflg_pkg::S_EMIT_TOT;
        end else begin
          cmd.op    = mflg_pkg::DP_BFS_POP;
          state_nxt = mflg_pkg::S_BFS_RD;
        end
      end
      mflg_pkg::S_BFS_RD: begin
        if (stat.bfs_arc_end) begin
          state_nxt = mflg_pkg::S_BFS_POP;
        end else begin
          cmd.op    = mflg_pkg::DP_ARC_RD;
          state_nxt = mflg_pkg::S_BFS_EVAL;
        end
      end
      mflg_pkg::S_BFS_EVAL: begin
        cmd.op    = mflg_pkg::DP_BFS_EVAL;
        state_nxt = mflg_pkg::S_BFS_RD;
      end
      mflg_pkg::S_DFS_INIT: begin
        cmd.op    = mflg_pkg::DP_DFS_INIT;
        state_nxt = mflg_pkg::S_ROOT;
      end
      mflg_pkg::S_ROOT: begin
        cmd.op    = mflg_pkg::DP_ROOT;
        state_nxt = mflg_pkg::S_ENTER;
      end
      mflg_pkg::S_ENTER: begin
        if (stat.at_term) begin
          cmd.op    = mflg_pkg::DP_RET_WANT;
          state_nxt = mflg_pkg::S_RET;
        end else begin
          state_nxt = mflg_pkg::S_SCAN;
        end
      end
      mflg_pkg::S_SCAN: begin
        if (stat.na_end) begin
          cmd.op    = mflg_pkg::DP_RET_GOT;
          state_nxt = mflg_pkg::S_RET;
        end else begin
          cmd.op    = mflg_pkg::DP_NA_RD;
          state_nxt = mflg_pkg::S_EVAL;
        end
      end
      mflg_pkg::S_EVAL: begin
        if (stat.eligible) begin
          cmd.op    = mflg_pkg::DP_DESCEND;
          state_nxt = mflg_pkg::S_ENTER;
        end else begin
          cmd.op    = mflg_pkg::DP_SKIP;
          state_nxt = mflg_pkg::S_SCAN;
        end
      end
      mflg_pkg::S_RET: begin
        if (stat.depth_zero) begin
          if (stat.ret_zero) begin
            state_nxt = mflg_pkg::S_BFS_INIT;
          end else begin
            cmd.op    = mflg_pkg::DP_ADD_TOTAL;
            state_nxt = mflg_pkg::S_ROOT;
          end
        end else begin
          cmd.op    = mflg_pkg::DP_POP;
          state_nxt = mflg_pkg::S_UPD_RD;
        end
      end
      mflg_pkg::S_UPD_RD: begin
        if (stat.ret_zero) begin
          cmd.op    = mflg_pkg::DP_SKIP;
          state_nxt = mflg_pkg::S_SCAN;
        end else begin
          cmd.op    = mflg_pkg::DP_NA_RD;
          state_nxt = mflg_pkg::S_UPD;
        end
      end
      mflg_pkg::S_UPD: begin
        cmd.op    = mflg_pkg::DP_UPD;
        state_nxt = stat.want_eq_ret ? mflg_pkg::S_RET : mflg_pkg::S_SCAN;
      end
      mflg_pkg::S_EMIT_TOT: begin
        if (stat.out_free) begin
          cmd.op    = mflg_pkg::DP_EMIT_TOT;
          state_nxt = mflg_pkg::S_EMIT_RD;
        end
      end
      mflg_pkg::S_EMIT_RD: begin
        if (stat.emit_end) begin
          cmd.op    = mflg_pkg::DP_FINISH;
          state_nxt = mflg_pkg::S_IDLE;
        end else begin
          cmd.op    = mflg_pkg::DP_EMIT_RD;
          state_nxt = mflg_pkg::S_EMIT_EDGE;
        end
      end
      mflg_pkg::S_EMIT_EDGE: begin
        if (stat.out_free) begin
          cmd.op    = mflg_pkg::DP_EMIT_EDGE;
          state_nxt = mflg_pkg::S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = mflg_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ design/mflg_dp.sv @@
`timescale 1ns / 1ps
module mflg_dp #(
  parameter int MAX_VERTICES = mflg_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = mflg_pkg::MAX_EDGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mflg_pkg::VC_W-1:0]          cfg_wdata,
  input  logic                               in_operation,
  input  logic [mflg_pkg::EP_W-1:0]          in_from_vertex,
  input  logic [mflg_pkg::EP_W-1:0]          in_to_vertex,
  input  logic [mflg_pkg::CAP_W-1:0]         in_capacity,
  input  mflg_pkg::dp_cmd_t                  cmd,
  output mflg_pkg::dp_stat_t                 stat,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [mflg_pkg::FLOW_W-1:0] out_flow_value,
  output logic                               out_is_total,
  output logic                               out_last_result
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int QW  = $clog2(MAX_VERTICES + 1);
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ARW = EW + 1;
  localparam int CW  = mflg_pkg::CMP_W;
  localparam int EPW = mflg_pkg::EP_W;
  localparam int CPW = mflg_pkg::CAP_W;
  localparam int EFW = mflg_pkg::EFLOW_W;
  localparam int RW  = mflg_pkg::RES_W;
  localparam int WW  = mflg_pkg::WANT_W;
  localparam int FW  = mflg_pkg::FLOW_W;
  localparam int ERW = 2 * EPW + CPW;

  // edge store
  logic [ERW-1:0] edge_mem [MAX_EDGES];
  logic [EFW-1:0] flow_mem [MAX_EDGES];
  logic [ERW-1:0] edge_rd_r;
  logic [EFW-1:0] flow_rd_r;

  logic [mflg_pkg::VC_W-1:0] vc_r;
  logic [EW-1:0]             ec_r;
  logic [FW-1:0]             total_r;

  // level graph
  logic              reached_r  [MAX_VERTICES];
  logic [VW-1:0]     level_r    [MAX_VERTICES];
  logic [ARW-1:0]    next_arc_r [MAX_VERTICES];
  logic [2*VW-1:0]   queue_r    [MAX_VERTICES];
  logic [QW-1:0]     head_r, tail_r;
  logic [VW-1:0]     bu_r, blvl_r;
  logic [ARW-1:0]    barc_r;
  logic              bfs_mode_r;
  logic              sink_hit_r;

  // augmenting path frames
  logic [VW-1:0]     u_r, depth_r;
  logic [WW-1:0]     want_r, got_r, ret_r;
  logic [VW-1:0]     stk_u_r    [MAX_VERTICES];
  logic [WW-1:0]     stk_want_r [MAX_VERTICES];
  logic [WW-1:0]     stk_got_r  [MAX_VERTICES];

  logic [EW-1:0]     eidx_r;
  logic              out_v_r;
  logic [FW-1:0]     out_flow_r;
  logic              out_tot_r, out_last_r;

  logic [CW-1:0]     vc_ext, live;
  logic [VW-1:0]     sink;
  logic [EPW-1:0]    e_start, e_end, e_tail, e_head;
  logic [CPW-1:0]    e_cap;
  logic [ARW-1:0]    na_cur, cur_arc, arc_lim;
  logic [VW-1:0]     cur_u, hv;
  logic              usable, r_pos;
  logic [RW-1:0]     cap_x, f_x, res;
  logic [WW-1:0]     res_w, want_c;
  logic [EFW-1:0]    f_new;
  logic [AW-1:0]     rd_addr;
  logic              rd_en;
  logic [VW-1:0]     nlvl;
  logic              bfs_take;

  assign vc_ext  = CW'(vc_r);
  assign live    = (vc_ext < CW'(2)) ? CW'(2) :
                   ((vc_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vc_ext);
  assign sink    = VW'(live - CW'(1));

  assign e_start = edge_rd_r[ERW-1 -: EPW];
  assign e_end   = edge_rd_r[CPW +: EPW];
  assign e_cap   = edge_rd_r[CPW-1:0];

  assign na_cur  = next_arc_r[u_r];
  assign arc_lim = {ec_r, 1'b0};
  assign cur_arc = bfs_mode_r ? barc_r : na_cur;
  assign cur_u   = bfs_mode_r ? bu_r : u_r;
  assign e_tail  = cur_arc[0] ? e_end : e_start;
  assign e_head  = cur_arc[0] ? e_start : e_end;
  assign hv      = VW'(e_head);
  assign usable  = (CW'(e_start) < live) && (CW'(e_end) < live);

  assign cap_x   = {{(RW-CPW){1'b0}}, e_cap};
  assign f_x     = {{(RW-EFW){flow_rd_r[EFW-1]}}, flow_rd_r};
  assign res     = cur_arc[0] ? (cap_x + f_x) : (cap_x - f_x);
  assign r_pos   = !res[RW-1] && (res != '0);
  assign res_w   = WW'(res);
  assign want_c  = (want_r < res_w) ? want_r : res_w;
  assign f_new   = na_cur[0] ? (flow_rd_r - EFW'(ret_r)) : (flow_rd_r + EFW'(ret_r));
  assign nlvl    = blvl_r + VW'(1);
  assign bfs_take = usable && (VW'(e_tail) == cur_u) && r_pos && !reached_r[hv] &&
                    (tail_r < QW'(MAX_VERTICES));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(eidx_r);
    case (cmd.op)
      mflg_pkg::DP_ARC_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(barc_r >> 1);
      end
      mflg_pkg::DP_NA_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(na_cur >> 1);
      end
      mflg_pkg::DP_EMIT_RD: begin
        rd_en = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    stat.in_solve     = (in_operation == mflg_pkg::OP_SOLVE);
    stat.bfs_empty    = (head_r == tail_r);
    stat.sink_reached = sink_hit_r;
    stat.bfs_arc_end  = (barc_r >= arc_lim);
    stat.na_end       = (na_cur >= arc_lim);
    stat.eligible     = usable && (VW'(e_tail) == u_r) && reached_r[hv] &&
                        ((VW+1)'(level_r[hv]) == (VW+1)'(depth_r) + (VW+1)'(1));
    stat.at_term      = (u_r == sink) || (want_r == '0);
    stat.depth_zero   = (depth_r == '0);
    stat.ret_zero     = (ret_r == '0);
    stat.want_eq_ret  = (want_r == ret_r);
    stat.out_free     = !out_v_r || out_ready;
    stat.emit_end     = (eidx_r == ec_r);
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.op == mflg_pkg::DP_LOAD && ec_r < EW'(MAX_EDGES)) begin
      edge_mem[AW'(ec_r)] <= {in_from_vertex, in_to_vertex, in_capacity};
    end
    if (rd_en) begin
      edge_rd_r <= edge_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == mflg_pkg::DP_LOAD && ec_r < EW'(MAX_EDGES)) begin
      flow_mem[AW'(ec_r)] <= '0;
    end else if (cmd.op == mflg_pkg::DP_UPD) begin
      flow_mem[AW'(na_cur >> 1)] <= f_new;
    end
    if (rd_en) begin
      flow_rd_r <= flow_mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r    <= mflg_pkg::VC_RESET;
      ec_r    <= '0;
      out_v_r <= 1'b0;
      head_r  <= '0;
      tail_r  <= '0;
      depth_r <= '0;
    end else begin
      if (cfg_we) begin
        vc_r <= cfg_wdata;
      end
      if (cmd.op == mflg_pkg::DP_LOAD && ec_r < EW'(MAX_EDGES)) begin
        ec_r <= ec_r + EW'(1);
      end else if (cmd.op == mflg_pkg::DP_FINISH) begin
        ec_r <= '0;
      end
      if (cmd.op == mflg_pkg::DP_EMIT_TOT || cmd.op == mflg_pkg::DP_EMIT_EDGE) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      case (cmd.op)
        mflg_pkg::DP_BFS_INIT: begin
          head_r <= '0;
          tail_r <= QW'(1);
        end
        mflg_pkg::DP_BFS_POP: begin
          head_r <= head_r + QW'(1);
        end
        mflg_pkg::DP_BFS_EVAL: begin
          if (bfs_take) begin
            tail_r <= tail_r + QW'(1);
          end
        end
        mflg_pkg::DP_ROOT: begin
          depth_r <= '0;
        end
        mflg_pkg::DP_DESCEND: begin
          depth_r <= depth_r + VW'(1);
        end
        mflg_pkg::DP_POP: begin
          depth_r <= depth_r - VW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      mflg_pkg::DP_START: begin
        total_r <= '0;
      end
      mflg_pkg::DP_BFS_INIT: begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
          reached_r[i] <= (i == 0);
        end
        level_r[0] <= '0;
        queue_r[0] <= '0;
        bfs_mode_r <= 1'b1;
        sink_hit_r <= 1'b0;
      end
      mflg_pkg::DP_BFS_POP: begin
        {bu_r, blvl_r} <= queue_r[VW'(head_r)];
        barc_r         <= '0;
      end
      mflg_pkg::DP_BFS_EVAL: begin
        if (bfs_take) begin
          reached_r[hv]          <= 1'b1;
          level_r[hv]            <= nlvl;
          queue_r[VW'(tail_r)]   <= {hv, nlvl};
          if (hv == sink) begin
            sink_hit_r <= 1'b1;
          end
        end
        barc_r <= barc_r + ARW'(1);
      end
      mflg_pkg::DP_DFS_INIT: begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
          next_arc_r[i] <= '0;
        end
        bfs_mode_r <= 1'b0;
      end
      mflg_pkg::DP_ROOT: begin
        u_r    <= '0;
        want_r <= mflg_pkg::PUSH_LIMIT;
        got_r  <= '0;
      end
      mflg_pkg::DP_DESCEND: begin
        stk_u_r[depth_r]    <= u_r;
        stk_want_r[depth_r] <= want_r;
        stk_got_r[depth_r]  <= got_r;
        u_r                 <= hv;
        want_r              <= want_c;
        got_r               <= '0;
      end
      mflg_pkg::DP_SKIP: begin
        next_arc_r[u_r] <= na_cur + ARW'(1);
      end
      mflg_pkg::DP_RET_WANT: begin
        ret_r <= want_r;
      end
      mflg_pkg::DP_RET_GOT: begin
        ret_r <= got_r;
      end
      mflg_pkg::DP_POP: begin
        u_r    <= stk_u_r[depth_r - VW'(1)];
        want_r <= stk_want_r[depth_r - VW'(1)];
        got_r  <= stk_got_r[depth_r - VW'(1)];
      end
      mflg_pkg::DP_ADD_TOTAL: begin
        total_r <= total_r + FW'(ret_r);
      end
      mflg_pkg::DP_UPD: begin
        if (want_r == ret_r) begin
          ret_r <= got_r + ret_r;
        end else begin
          got_r           <= got_r + ret_r;
          want_r          <= want_r - ret_r;
          next_arc_r[u_r] <= na_cur + ARW'(1);
        end
      end
      mflg_pkg::DP_EMIT_TOT: begin
        out_flow_r <= total_r;
        out_tot_r  <= 1'b1;
        out_last_r <= (ec_r == '0);
        eidx_r     <= '0;
      end
      mflg_pkg::DP_EMIT_EDGE: begin
        out_flow_r <= {{(FW-EFW){flow_rd_r[EFW-1]}}, flow_rd_r};
        out_tot_r  <= 1'b0;
        out_last_r <= ((eidx_r + EW'(1)) == ec_r);
        eidx_r     <= eidx_r + EW'(1);
      end
      default: begin
      end
    endcase
  end

  assign out_valid       = out_v_r;
  assign out_flow_value  = signed'(out_flow_r);
  assign out_is_total    = out_tot_r;
  assign out_last_result = out_last_r;

  a_ec_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ec_r <= EW'(MAX_EDGES))
    else $error("edge count past store depth");

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("bfs queue head passed tail");

  a_descend_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == mflg_pkg::DP_DESCEND |-> depth_r < VW'(MAX_VERTICES - 1))
    else $error("path deeper than level count");

  a_pop_nonroot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == mflg_pkg::DP_POP |=> depth_r == $past(depth_r) - VW'(1))
    else $error("frame pop underflow");

endmodule

@@ design/max_flow_level_graph.sv @@
`timescale 1ns / 1ps
// Dinic max flow over up to MAX_EDGES undirected edges and MAX_VERTICES vertices,
// source vertex 0, sink vertex vertex_count-1, with the count clamped to
// 2..MAX_VERTICES. An add beat stores one edge while the store has room. A solve
// beat then runs phases: each level build scans every arc from each reached
// vertex (one registered read of the edge store per arc), and the depth-first
// push tries arcs, steps down and steps back along each found path. Every arc
// read goes through the edge store's single read port. Results follow: the
// total, then one beat per stored edge, each held while the output is not free.
// No new beat is taken until the last result is queued.
module max_flow_level_graph #(
  parameter int MAX_VERTICES = mflg_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = mflg_pkg::MAX_EDGES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [mflg_pkg::VC_W-1:0] cfg_wdata,
  mflg_in_if.sink                   in_beat,
  mflg_out_if.source                out_beat
);

  mflg_pkg::dp_cmd_t  cmd;
  mflg_pkg::dp_stat_t stat;

  mflg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_beat.valid),
    .in_ready (in_beat.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mflg_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_operation    (in_beat.operation),
    .in_from_vertex  (in_beat.from_vertex),
    .in_to_vertex    (in_beat.to_vertex),
    .in_capacity     (in_beat.capacity),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_beat.valid),
    .out_ready       (out_beat.ready),
    .out_flow_value  (out_beat.flow_value),
    .out_is_total    (out_beat.is_total),
    .out_last_result (out_beat.last_result)
  );

endmodule

@@ verif/max_flow_level_graph_test.sv @@
`timescale 1ns / 1ps
module max_flow_level_graph_test;

  localparam int N_VERT    = mflg_pkg::MAX_VERTICES_DEF;
  localparam int N_EDGE    = mflg_pkg::MAX_EDGES_DEF;
  localparam int EPW       = mflg_pkg::EP_W;
  localparam int CPW       = mflg_pkg::CAP_W;
  localparam int VCW       = mflg_pkg::VC_W;
  localparam int FLW       = mflg_pkg::FLOW_W;
  localparam int IDLE_MAX  = 400000;
  localparam int TAIL_WAIT = 50;
  localparam longint PUSH_LIM = 64'd1 << 40;

  typedef enum int { ROW_BEAT, ROW_CFG, ROW_DRAIN } row_kind_t;

  typedef struct {
    row_kind_t             kind;
    mflg_pkg::op_t         op;
    logic [EPW-1:0]        fv;
    logic [EPW-1:0]        tv;
    logic [CPW-1:0]        cap;
    logic [VCW-1:0]        cfgv;
    int                    nfix;
    logic signed [FLW-1:0] fix_tot;
    logic signed [FLW-1:0] fix_edge;
    bit                    hold;
  } stim_row_t;

  typedef struct {
    logic signed [FLW-1:0] val;
    logic                  tot;
    logic                  last;
  } flow_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [VCW-1:0] cfg_wdata = '0;

  mflg_in_if  in_beat();
  mflg_out_if out_beat();

  max_flow_level_graph i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_beat  (in_beat.sink),
    .out_beat (out_beat.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  flow_beat_t flow_q[$];
  flow_beat_t solve_out[$];
  stim_row_t  rows[$];
  int mismatches = 0;
  int rx_count = 0;
  int idle_cycles = 0;
  bit hold_go = 1'b0;

  // graph model
  logic [EPW-1:0]  g_from[N_EDGE];
  logic [EPW-1:0]  g_to[N_EDGE];
  logic [CPW-1:0]  g_cap[N_EDGE];
  longint          g_flow[N_EDGE];
  int              g_cnt = 0;
  logic [VCW-1:0]  g_vc = mflg_pkg::VC_RESET;
  int              live, sink;
  int              lvl[N_VERT];
  bit              reached[N_VERT];
  int              nxt[N_VERT];

  function automatic bit usable(int e);
    return int'(g_from[e]) < live && int'(g_to[e]) < live;
  endfunction

  function automatic int arc_tail(int a);
    return a[0] ? int'(g_to[a >> 1]) : int'(g_from[a >> 1]);
  endfunction

  function automatic int arc_head(int a);
    return a[0] ? int'(g_from[a >> 1]) : int'(g_to[a >> 1]);
  endfunction

  function automatic longint residual(int a);
    longint c;
    c = longint'(g_cap[a >> 1]);
    return a[0] ? c + g_flow[a >> 1] : c - g_flow[a >> 1];
  endfunction

  function automatic bit build_levels();
    int q[N_VERT];
    int hd, tl, u, v, a;
    hd = 0;
    tl = 0;
    for (int i = 0; i < N_VERT; i++) reached[i] = 0;
    reached[0] = 1;
    lvl[0] = 0;
    q[tl] = 0;
    tl = tl + 1;
    while (hd < tl) begin
      u = q[hd];
      hd = hd + 1;
      for (a = 0; a < 2 * g_cnt; a++) begin
        if (usable(a >> 1) && arc_tail(a) == u) begin
          v = arc_head(a);
          if (residual(a) > 0 && !reached[v] && tl < N_VERT) begin
            reached[v] = 1;
            lvl[v] = lvl[u] + 1;
            q[tl] = v;
            tl = tl + 1;
          end
        end
      end
    end
    return reached[sink];
  endfunction

  function automatic bit arc_ok(int a, int u);
    int v;
    if (!usable(a >> 1) || arc_tail(a) != u) return 0;
    v = arc_head(a);
    return reached[v] && lvl[v] == lvl[u] + 1;
  endfunction

  // depth-first augmentation with explicit frames
  function automatic longint push_path();
    int fvx[N_VERT+1];
    longint fw[N_VERT+1];
    longint fg[N_VERT+1];
    int fa[N_VERT+1];
    int d, u, v, a;
    longint r, w, ret;
    bit back, done;
    d = 0;
    fvx[0] = 0;
    fw[0] = PUSH_LIM;
    fg[0] = 0;
    back = 0;
    done = 0;
    ret = 0;
    while (!done) begin
      u = fvx[d];
      if (back) begin
        back = 0;
        a = fa[d];
        if (ret != 0) begin
          if (a[0]) g_flow[a >> 1] -= ret;
          else g_flow[a >> 1] += ret;
          fg[d] += ret;
          fw[d] -= ret;
        end
        if (ret != 0 && fw[d] == 0) begin
          ret = fg[d];
          if (d == 0) done = 1;
          else begin
            d--;
            back = 1;
          end
        end else begin
          nxt[u]++;
        end
      end else begin
        while (nxt[u] < 2 * g_cnt && !arc_ok(nxt[u], u)) nxt[u]++;
        if (nxt[u] >= 2 * g_cnt) begin
          ret = fg[d];
          if (d == 0) done = 1;
          else begin
            d--;
            back = 1;
          end
        end else begin
          a = nxt[u];
          fa[d] = a;
          v = arc_head(a);
          r = residual(a);
          w = fw[d] < r ? fw[d] : r;
          if (v == sink || w == 0) begin
            ret = w;
            back = 1;
          end else begin
            d++;
            fvx[d] = v;
            fw[d] = w;
            fg[d] = 0;
          end
        end
      end
    end
    return ret;
  endfunction

  task automatic predict_beat(input mflg_pkg::op_t op, input logic [EPW-1:0] fv,
                              input logic [EPW-1:0] tv, input logic [CPW-1:0] cap);
    longint total, f;
    flow_beat_t b;
    solve_out.delete();
    if (op == mflg_pkg::OP_ADD) begin
      if (g_cnt < N_EDGE) begin
        g_from[g_cnt] = fv;
        g_to[g_cnt] = tv;
        g_cap[g_cnt] = cap;
        g_flow[g_cnt] = 0;
        g_cnt++;
      end
    end else begin
      live = g_vc < 2 ? 2 : (g_vc > N_VERT ? N_VERT : int'(g_vc));
      sink = live - 1;
      for (int e = 0; e < g_cnt; e++) g_flow[e] = 0;
      total = 0;
      while (build_levels()) begin
        for (int i = 0; i < N_VERT; i++) nxt[i] = 0;
        f = push_path();
        while (f != 0) begin
          total += f;
          f = push_path();
        end
      end
      b.val = total[FLW-1:0];
      b.tot = 1'b1;
      b.last = (g_cnt == 0);
      solve_out.insert(solve_out.size(), b);
      for (int e = 0; e < g_cnt; e++) begin
        b.val = g_flow[e][FLW-1:0];
        b.tot = 1'b0;
        b.last = (e + 1 == g_cnt);
        solve_out.insert(solve_out.size(), b);
      end
      g_cnt = 0;
    end
  endtask

  function automatic stim_row_t beat_row(mflg_pkg::op_t op, int fv, int tv,
                                         logic [CPW-1:0] cap);
    stim_row_t r;
    r.kind = ROW_BEAT;
    r.op = op;
    r.fv = EPW'(fv);
    r.tv = EPW'(tv);
    r.cap = cap;
    r.cfgv = '0;
    r.nfix = 0;
    r.fix_tot = '0;
    r.fix_edge = '0;
    r.hold = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(int v);
    stim_row_t r;
    r = beat_row(mflg_pkg::OP_ADD, 0, 0, '0);
    r.kind = ROW_CFG;
    r.cfgv = VCW'(v);
    return r;
  endfunction

  function automatic logic [CPW-1:0] rand_cap();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return $urandom_range(0, 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(input stim_row_t r);
    rows.insert(rows.size(), r);
  endtask

  task automatic build_stimulus();
    stim_row_t r;
    int vc, cur_vc, effv, ne, items;
    // directed
    r = beat_row(mflg_pkg::OP_SOLVE, 0, 0, '0);
    r.nfix = 1;
    r.fix_tot = '0;
    add_row(r);
    add_row(beat_row(mflg_pkg::OP_ADD, 0, 1, '1));
    r = beat_row(mflg_pkg::OP_SOLVE, 15, 15, '1);
    r.nfix = 2;
    r.fix_tot = 38'sd4294967295;
    r.fix_edge = 38'sd4294967295;
    add_row(r);
    add_row(beat_row(mflg_pkg::OP_ADD, 1, 0, 5));
    add_row(beat_row(mflg_pkg::OP_SOLVE, 0, 0, '0));
    add_row(cfg_row(0));
    add_row(beat_row(mflg_pkg::OP_ADD, 0, 0, 7));
    add_row(beat_row(mflg_pkg::OP_ADD, 0, 3, 9));
    add_row(beat_row(mflg_pkg::OP_ADD, 0, 1, '0));
    add_row(beat_row(mflg_pkg::OP_ADD, 1, 1, 3));
    add_row(beat_row(mflg_pkg::OP_SOLVE, 0, 0, '0));
    add_row(cfg_row(31));
    add_row(beat_row(mflg_pkg::OP_ADD, 0, 15, '1));
    add_row(beat_row(mflg_pkg::OP_ADD, 15, 0, '1));
    add_row(beat_row(mflg_pkg::OP_ADD, 0, 7, '1));
    add_row(beat_row(mflg_pkg::OP_ADD, 7, 15, '1));
    add_row(beat_row(mflg_pkg::OP_SOLVE, 0, 0, '0));
    add_row(cfg_row(16));
    add_row(beat_row(mflg_pkg::OP_ADD, 0, 5, 10));
    add_row(beat_row(mflg_pkg::OP_ADD, 5, 15, 4));
    add_row(beat_row(mflg_pkg::OP_ADD, 0, 15, 6));
    add_row(beat_row(mflg_pkg::OP_SOLVE, 0, 0, '0));
    add_row(cfg_row(1));
    add_row(beat_row(mflg_pkg::OP_ADD, 1, 0, 2));
    add_row(beat_row(mflg_pkg::OP_SOLVE, 0, 0, '0));
    // random graphs
    items = 0;
    cur_vc = 1;
    for (int ph = 0; items < 230; ph++) begin
      case ($urandom_range(0, 9))
        0: vc = 2;
        1: vc = 16;
        2: vc = $urandom_range(0, 31);
        default: vc = $urandom_range(3, 8);
      endcase
      if (ph == 0) vc = 16;
      // some graphs keep the vertex count so adds queue up behind a solve
      if (ph == 0 || (ph != 1 && $urandom_range(0, 2) != 0)) begin
        cur_vc = vc;
        add_row(cfg_row(vc));
      end
      effv = cur_vc < 2 ? 2 : (cur_vc > N_VERT ? N_VERT : cur_vc);
      if (ph == 0) ne = N_EDGE + 3;
      else if ($urandom_range(0, 7) == 0) ne = $urandom_range(20, N_EDGE);
      else ne = $urandom_range(0, 10);
      for (int i = 0; i < ne; i++) begin
        if ($urandom_range(0, 99) < 85)
          r = beat_row(mflg_pkg::OP_ADD, $urandom_range(0, effv - 1),
                       $urandom_range(0, effv - 1), rand_cap());
        else
          r = beat_row(mflg_pkg::OP_ADD, $urandom_range(0, 15), $urandom_range(0, 15),
                       rand_cap());
        add_row(r);
      end
      r = beat_row(mflg_pkg::OP_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom);
      if (ph == 0) r.hold = 1'b1;
      add_row(r);
      items += ne + 1;
      if (ph == 6) begin
        r = cfg_row(0);
        r.kind = ROW_DRAIN;
        add_row(r);
      end
    end
  endtask

  task automatic wait_drained();
    while (flow_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    int gap;
    stim_row_t r;
    in_beat.valid = 1'b0;
    in_beat.operation = mflg_pkg::OP_ADD;
    in_beat.from_vertex = '0;
    in_beat.to_vertex = '0;
    in_beat.capacity = '0;
    build_stimulus();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    foreach (rows[i]) begin
      r = rows[i];
      if (r.kind != ROW_BEAT) begin
        in_beat.valid = 1'b0;
        wait_drained();
        if (r.kind == ROW_CFG) begin
          cfg_we = 1'b1;
          cfg_wdata = r.cfgv;
          g_vc = r.cfgv;
          @(negedge clk);
          cfg_we = 1'b0;
        end
      end else begin
        if (r.hold) hold_go = 1'b1;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
          in_beat.valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
        in_beat.valid = 1'b1;
        in_beat.operation = r.op;
        in_beat.from_vertex = r.fv;
        in_beat.to_vertex = r.tv;
        in_beat.capacity = r.cap;
        do @(posedge clk); while (!in_beat.ready);
        predict_beat(r.op, r.fv, r.tv, r.cap);
        if (r.nfix != 0) begin
          solve_out[0].val = r.fix_tot;
          if (r.nfix > 1) solve_out[1].val = r.fix_edge;
        end
        foreach (solve_out[k]) flow_q.insert(flow_q.size(), solve_out[k]);
        @(negedge clk);
      end
    end
    in_beat.valid = 1'b0;
    while (flow_q.size() != 0) @(negedge clk);
    repeat (TAIL_WAIT) @(negedge clk);
    if (mismatches == 0 && flow_q.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    int gap;
    bit held;
    held = 0;
    out_beat.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && hold_go) begin
        // long hold-off once results show up, so the input stalls behind them
        out_beat.ready = 1'b0;
        while (!out_beat.valid) @(negedge clk);
        repeat (250) @(negedge clk);
        held = 1;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
        out_beat.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_beat.ready = 1'b1;
      do @(posedge clk); while (!out_beat.valid);
    end
  end

  always @(posedge clk) begin
    flow_beat_t exp_b;
    if (rst_n && out_beat.valid && out_beat.ready) begin
      rx_count++;
      if (flow_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: flow %0d total %0b last %0b",
                   out_beat.flow_value, out_beat.is_total, out_beat.last_result);
      end else begin
        exp_b = flow_q.pop_front();
        if (out_beat.flow_value !== exp_b.val || out_beat.is_total !== exp_b.tot ||
            out_beat.last_result !== exp_b.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp flow %0d total %0b last %0b, ",
                      "got flow %0d total %0b last %0b"},
                     exp_b.val, exp_b.tot, exp_b.last,
                     out_beat.flow_value, out_beat.is_total, out_beat.last_result);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_beat.valid && in_beat.ready) || (out_beat.valid && out_beat.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_MAX) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
